/* hdl/bpk_pkg.sv */
// ----------------------------------------------------------------------------
// bpk_pkg
// Shared types and helpers for the byte to packet bit packer.
// ----------------------------------------------------------------------------
package bpk_pkg;

    localparam int unsigned BYTE_BITS   = 8;
    localparam int unsigned PKT_BITS    = 32;
    localparam int unsigned CNT_BITS    = 6;
    localparam int unsigned REM_BITS    = 4;

    localparam logic [CNT_BITS-1:0] WIDTH_RESET = 6'd8;

    typedef struct packed {
        logic [PKT_BITS-1:0] bits;
        logic [CNT_BITS-1:0] count;
        logic                last;
        logic                done;
    } t_result;

    // Register value to working width: zero acts as one, clamp to limit.
    function automatic logic [CNT_BITS-1:0] f_eff_width(
        input logic [CNT_BITS-1:0] cfg,
        input logic [CNT_BITS-1:0] limit
    );
        logic [CNT_BITS-1:0] w;
        w = (cfg == '0) ? 6'd1 : cfg;
        if (w > limit) begin
            w = limit;
        end
        return w;
    endfunction

endpackage

/* hdl/bpk_unpack.sv */
// ----------------------------------------------------------------------------
// bpk_unpack
// Byte holding register and packing step: moves bits of the held byte into
// the partial packet and produces at most one packet per cycle.
// ----------------------------------------------------------------------------
module bpk_unpack (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [bpk_pkg::CNT_BITS-1:0]  i_width,
    input  logic                          i_clear,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [bpk_pkg::BYTE_BITS-1:0] i_data_byte,
    input  logic                          i_end_of_source,
    input  logic                          i_out_free,
    output logic                          o_emit,
    output bpk_pkg::t_result              o_result
);
    import bpk_pkg::*;

    logic                  r_vld;
    logic [BYTE_BITS-1:0]  r_byte;
    logic [REM_BITS-1:0]   r_rem;
    logic                  r_end;
    logic [PKT_BITS-1:0]   r_partial;
    logic [CNT_BITS-1:0]   r_filled;

    logic [CNT_BITS-1:0]   need;
    logic [REM_BITS-1:0]   take;
    logic [REM_BITS-1:0]   rem_after;
    logic [BYTE_BITS-1:0]  top_bits;
    logic [BYTE_BITS-1:0]  byte_next;
    logic [PKT_BITS-1:0]   acc;
    logic [CNT_BITS-1:0]   filled_sum;
    logic                  fill;
    logic                  absorb;
    logic                  emit;
    logic                  byte_done;
    logic                  advance;
    t_result               res;

    logic [PKT_BITS-1:0]   n_partial;
    logic [CNT_BITS-1:0]   n_filled;
    logic [BYTE_BITS-1:0]  n_byte;
    logic [REM_BITS-1:0]   n_rem;

    always_comb begin
        need       = i_width - r_filled;
        take       = ({2'b00, r_rem} < need) ? r_rem : need[REM_BITS-1:0];
        rem_after  = r_rem - take;
        top_bits   = r_byte >> (4'd8 - take);
        byte_next  = r_byte << take;
        acc        = (r_partial << take) | {{(PKT_BITS-BYTE_BITS){1'b0}}, top_bits};
        filled_sum = r_filled + {2'b00, take};
        fill       = (filled_sum == i_width);
        // leftover bits of the byte fit in the next packet and need no flush
        absorb     = fill && (rem_after != '0) && ({2'b00, rem_after} < i_width) && !r_end;

        res        = '0;
        emit       = 1'b0;
        byte_done  = 1'b1;
        n_byte     = byte_next;
        n_rem      = rem_after;
        n_partial  = '0;
        n_filled   = '0;

        if (fill) begin
            emit       = 1'b1;
            res.bits   = acc;
            res.count  = i_width;
            byte_done  = (rem_after == '0) || absorb;
            res.last   = byte_done;
            res.done   = byte_done && r_end;
            if (absorb) begin
                n_partial = {{(PKT_BITS-BYTE_BITS){1'b0}}, byte_next >> (4'd8 - rem_after)};
                n_filled  = {2'b00, rem_after};
            end
        end else if (r_end) begin
            if (filled_sum != '0) begin
                emit      = 1'b1;
                res.bits  = acc << (i_width - filled_sum);
                res.count = filled_sum;
                res.last  = 1'b1;
                res.done  = 1'b1;
            end
        end else begin
            n_partial = acc;
            n_filled  = filled_sum;
        end

        advance  = r_vld && (!emit || i_out_free);
        o_ready  = !r_vld || (advance && byte_done);
        o_emit   = r_vld && emit && i_out_free;
        o_result = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_partial <= '0;
            r_filled  <= '0;
        end else begin
            if (i_valid && o_ready) begin
                r_vld <= 1'b1;
            end else if (advance && byte_done) begin
                r_vld <= 1'b0;
            end
            if (i_clear) begin
                r_partial <= '0;
                r_filled  <= '0;
            end else if (advance) begin
                r_partial <= n_partial;
                r_filled  <= n_filled;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_data_byte;
            r_rem  <= 4'd8;
            r_end  <= i_end_of_source;
        end else if (advance) begin
            r_byte <= n_byte;
            r_rem  <= n_rem;
        end
    end

`ifndef SYNTHESIS
    a_filled_below_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled < i_width)
        else $error("partial fill reached packet width");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> (r_rem != '0) && (r_rem <= 4'd8))
        else $error("held byte has no bits left");
`endif

endmodule

/* hdl/bpk_out_reg.sv */
// ----------------------------------------------------------------------------
// bpk_out_reg
// Result register: holds one packet until the downstream side takes it.
// ----------------------------------------------------------------------------
module bpk_out_reg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  bpk_pkg::t_result             i_result,
    output logic                         o_free,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [bpk_pkg::PKT_BITS-1:0] o_packet_bits,
    output logic [bpk_pkg::CNT_BITS-1:0] o_valid_bit_count,
    output logic                         o_last_of_run,
    output logic                         o_stream_done
);
    import bpk_pkg::*;

    logic    r_vld;
    t_result r_res;

    assign o_free = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

    assign o_valid           = r_vld;
    assign o_packet_bits     = r_res.bits;
    assign o_valid_bit_count = r_res.count;
    assign o_last_of_run     = r_res.last;
    assign o_stream_done     = r_res.done;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("result loaded over a waiting beat");
`endif

endmodule

/* hdl/byte_to_packet_bit_packer_unit.sv */
// Each packet of a held byte is loaded into the result register that drives o_valid.
// Throughput, while i_ready is high: one byte per cycle while it yields at most one packet;
// otherwise one packet per cycle, as the single result register takes one per cycle.
// A flush of a partial packet after a packet ending in the same byte is emitted after it.
// Reset (synchronous, active low) empties both registers and the partial packet,
// and sets packet width to 8.
// ----------------------------------------------------------------------------
// byte_to_packet_bit_packer_unit
// Reslices a byte stream, MSB first, into packets of 1 to 32 bits with flush
// of a partial packet on the last byte.
// ----------------------------------------------------------------------------
module byte_to_packet_bit_packer_unit #(
    parameter int unsigned MAX_PACKET_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bpk_pkg::CNT_BITS-1:0] i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [bpk_pkg::BYTE_BITS-1:0] i_data_byte,
    input  logic                         i_end_of_source,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [bpk_pkg::PKT_BITS-1:0] o_packet_bits,
    output logic [bpk_pkg::CNT_BITS-1:0] o_valid_bit_count,
    output logic                         o_last_of_run,
    output logic                         o_stream_done
);
    import bpk_pkg::*;

    localparam logic [CNT_BITS-1:0] WIDTH_LIMIT =
        CNT_BITS'((MAX_PACKET_WIDTH < PKT_BITS) ? MAX_PACKET_WIDTH : PKT_BITS);

    logic [CNT_BITS-1:0] r_pkt_width;
    logic [CNT_BITS-1:0] width;
    logic                out_free;
    logic                emit;
    t_result             result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_width <= WIDTH_RESET;
        end else if (i_cfg_we) begin
            r_pkt_width <= i_cfg_wdata;
        end
    end

    assign width = f_eff_width(r_pkt_width, WIDTH_LIMIT);

    bpk_unpack u_unpack (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_width        (width),
        .i_clear        (i_cfg_we),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_end_of_source(i_end_of_source),
        .i_out_free     (out_free),
        .o_emit         (emit),
        .o_result       (result)
    );

    bpk_out_reg u_out_reg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (emit),
        .i_result         (result),
        .o_free           (out_free),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_packet_bits    (o_packet_bits),
        .o_valid_bit_count(o_valid_bit_count),
        .o_last_of_run    (o_last_of_run),
        .o_stream_done    (o_stream_done)
    );

`ifndef SYNTHESIS
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_stream_done) |-> (o_valid_bit_count == width))
        else $error("short packet without end of source");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stream_done) |-> o_last_of_run)
        else $error("end of source beat not last of its byte");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_valid_bit_count != '0) && (o_valid_bit_count <= width))
        else $error("bad bit count on output beat");
`endif

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the byte to packet bit packer. A local packing model
// predicts every packet from each accepted byte beat; a checker compares each
// output beat field by field. Directed cases cover the width extremes and the
// flush cases, then random source streams run under several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpk_pkg::*;

    localparam int unsigned PK_LIMIT      = 32;    // packing limit of the instance
    localparam int unsigned IDLE_LIMIT    = 2000;  // cycles with no beat before giving up
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned HOLD_CYCLES   = 300;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_we        = 1'b0;
    logic [CNT_BITS-1:0]  i_cfg_wdata     = '0;
    logic                 i_valid         = 1'b0;
    logic                 o_ready;
    logic [BYTE_BITS-1:0] i_data_byte     = '0;
    logic                 i_end_of_source = 1'b0;
    logic                 o_valid;
    logic                 i_ready         = 1'b0;
    logic [PKT_BITS-1:0]  o_packet_bits;
    logic [CNT_BITS-1:0]  o_valid_bit_count;
    logic                 o_last_of_run;
    logic                 o_stream_done;

    // packing model state
    logic [PKT_BITS-1:0]  model_partial   = '0;
    int unsigned          model_filled    = 0;
    logic [CNT_BITS-1:0]  model_width_reg = WIDTH_RESET;

    t_result     pending_packets[$];
    int unsigned mismatch_cnt   = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_req       = 0;
    int unsigned hold_left      = 0;
    int unsigned quiet_cycles   = 0;

    byte_to_packet_bit_packer_unit u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_data_byte       (i_data_byte),
        .i_end_of_source   (i_end_of_source),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_packet_bits     (o_packet_bits),
        .o_valid_bit_count (o_valid_bit_count),
        .o_last_of_run     (o_last_of_run),
        .o_stream_done     (o_stream_done)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int unsigned working_width(input logic [CNT_BITS-1:0] reg_val);
        if (reg_val == '0) begin
            return 1;
        end
        if (reg_val > PK_LIMIT) begin
            return PK_LIMIT;
        end
        return 32'(reg_val);
    endfunction

    // Appends the packets one byte beat produces to the pending queue.
    task automatic pack_byte_model(input logic [BYTE_BITS-1:0] data_in, input logic eos);
        t_result     outs [0:8];
        int          n;
        int unsigned w;
        n = 0;
        w = working_width(model_width_reg);
        if (model_filled >= w) begin
            model_partial = '0;
            model_filled  = 0;
        end
        for (int i = BYTE_BITS - 1; i >= 0; i--) begin
            model_partial = {model_partial[PKT_BITS-2:0], data_in[i]};
            model_filled++;
            if (model_filled == w) begin
                outs[n].bits  = model_partial;
                outs[n].count = CNT_BITS'(w);
                outs[n].last  = 1'b0;
                outs[n].done  = 1'b0;
                n++;
                model_partial = '0;
                model_filled  = 0;
            end
        end
        // flush: real bits left-aligned within the packet
        if (eos && model_filled > 0) begin
            outs[n].bits  = model_partial << (w - model_filled);
            outs[n].count = CNT_BITS'(model_filled);
            outs[n].last  = 1'b0;
            outs[n].done  = 1'b0;
            n++;
        end
        if (n > 0) begin
            outs[n-1].last = 1'b1;
            outs[n-1].done = eos;
        end
        for (int k = 0; k < n; k++) begin
            pending_packets = {pending_packets, outs[k]};
        end
        if (eos) begin
            model_partial = '0;
            model_filled  = 0;
        end
    endtask

    task automatic send_byte(input logic [BYTE_BITS-1:0] data_in, input logic eos);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) begin
                @(posedge i_clk);
            end
        end
        i_valid         <= 1'b1;
        i_data_byte     <= data_in;
        i_end_of_source <= eos;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        pack_byte_model(data_in, eos);
    endtask

    task automatic drain_outputs();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_packets.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // A byte that makes no packet may still be in flight when the queue empties.
    task automatic wait_idle();
        drain_outputs();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_width(input logic [CNT_BITS-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we        <= 1'b0;
        model_width_reg = v;
        model_partial   = '0;
        model_filled    = 0;
    endtask

    task automatic test_reset_width();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h3C, 1'b1);
        wait_idle();
    endtask

    task automatic test_width_extremes();
        write_width(6'd1);
        send_byte(8'h96, 1'b0);
        send_byte(8'h01, 1'b1);
        wait_idle();
        write_width(6'd0);          // zero acts as one
        send_byte(8'h80, 1'b1);
        wait_idle();
        write_width(6'd32);
        send_byte(8'h12, 1'b0);     // no packet from these
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        send_byte(8'h78, 1'b1);     // exact fill on the last byte
        send_byte(8'hFF, 1'b1);
        wait_idle();
        write_width(6'd63);         // clamps to the limit
        send_byte(8'hDE, 1'b1);
        wait_idle();
        write_width(6'd33);
        send_byte(8'hAD, 1'b0);
        send_byte(8'hBE, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'h01, 1'b1);
        wait_idle();
    endtask

    task automatic test_partial_flush();
        write_width(6'd5);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h0F, 1'b1);     // two packets and a flush from one byte
        wait_idle();
        write_width(6'd3);
        send_byte(8'hAA, 1'b1);
        wait_idle();
        write_width(6'd4);
        send_byte(8'h5A, 1'b1);
        wait_idle();
        write_width(6'd5);
        send_byte(8'hFF, 1'b0);     // leaves three bits pending
        wait_idle();
        write_width(6'd6);          // discards them
        send_byte(8'h81, 1'b1);
        wait_idle();
    endtask

    // Output held off long enough that the input side has to stall.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_width(6'd1);
        hold_req = HOLD_CYCLES;
        for (int k = 0; k < 40; k++) begin
            send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
        end
        wait_idle();
    endtask

    task automatic test_random_streams(input int unsigned send_pct, input int unsigned recv_pct,
                                       input int unsigned n_items);
        int unsigned         sent;
        int unsigned         len;
        bit                  paused;
        logic [CNT_BITS-1:0] w;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_items) begin
            if ($urandom_range(5) == 0) begin
                wait_idle();
                if ($urandom_range(3) == 0) begin
                    w = CNT_BITS'($urandom_range(63));
                end else begin
                    w = CNT_BITS'($urandom_range(12, 1));
                end
                write_width(w);
            end
            // most streams end on a marked byte; some run on unterminated
            len = $urandom_range(10, 1);
            for (int k = 0; k < len; k++) begin
                send_byte(8'($urandom_range(255)),
                          (k == len - 1) && ($urandom_range(7) != 0));
            end
            sent += len;
            if (!paused && sent >= n_items / 2) begin
                paused = 1'b1;
                drain_outputs();
            end
        end
        wait_idle();
    endtask

    function automatic void check_field(input string name, input logic [PKT_BITS-1:0] want,
                                        input logic [PKT_BITS-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_cnt++;
        end
    endfunction

    // output beat checker and ready driver
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_packets.size() == 0) begin
                $display("%0t: unexpected packet, expected none, actual bits=%h count=%0d",
                         $time, o_packet_bits, o_valid_bit_count);
                mismatch_cnt++;
            end else begin
                want = pending_packets.pop_front();
                check_field("packet_bits", want.bits, o_packet_bits);
                check_field("valid_bit_count", PKT_BITS'(want.count), PKT_BITS'(o_valid_bit_count));
                check_field("last_of_run", PKT_BITS'(want.last), PKT_BITS'(o_last_of_run));
                check_field("stream_done", PKT_BITS'(want.done), PKT_BITS'(o_stream_done));
            end
        end
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_width();
        test_width_extremes();
        test_partial_flush();
        test_backpressure();
        test_random_streams(0, 0, 90);
        test_random_streams(71, 0, 90);
        test_random_streams(0, 71, 90);
        test_random_streams(21, 21, 90);
        wait_idle();
        if (mismatch_cnt == 0 && pending_packets.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/bpk_pkg.sv
hdl/bpk_unpack.sv
hdl/bpk_out_reg.sv
hdl/byte_to_packet_bit_packer_unit.sv
tb/tb.sv
